// ===== src/hcbd_pkg.sv =====
// Package for the chunked body decoder: shared types, character codes and event codes.
// No dependencies; every other file of the block but hcbd_if imports it.
package hcbd_pkg;

   localparam int SIZE_W = 64;

   // Character codes
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SP      = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_DIG0    = 8'h30;
   localparam logic [7:0] CH_DIG9    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_DATA  = 3'd1,
      PH_TRAIL = 3'd2,
      PH_DONE  = 3'd3,
      PH_FAIL  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD   = 2'd0,
      EV_LAST      = 2'd1,
      EV_MALFORMED = 2'd2
   } event_type;

   // Progress through one size line
   typedef struct packed {
      logic [SIZE_W-1:0] acc;
      logic              digit_seen;
      logic              digits_closed;
      logic              cr_pending;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{acc: '0, digit_seen: 1'b0,
                                             digits_closed: 1'b0, cr_pending: 1'b0};

   localparam logic [SIZE_W-1:0] TRAIL_LEN = SIZE_W'(2);

   typedef struct packed {
      logic [7:0] body_byte;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      event_type  event_res;
   } rsp_item_type;

endpackage

// ===== src/hcbd_if.sv =====
// Handshake channels of the chunked body decoder: request (raw bytes) and response (results).
// Depends on nothing but the clock domain of the block.
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       restart;

   modport source (output valid, output body_byte, output restart, input ready);
   modport sink   (input valid, input body_byte, input restart, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [1:0] event_res;

   modport source (output valid, output payload_byte, output event_res, input ready);
   modport sink   (input valid, input payload_byte, input event_res, output ready);
endinterface

// ===== src/hcbd_line.sv =====
// Size-line parser: folds one byte (plus any held CR) into the line state.
// Depends on hcbd_pkg.
module hcbd_line
   import hcbd_pkg::*;
(
   input  line_state_type cur,
   input  logic [7:0]     c,
   output line_state_type nxt,
   output logic           size_line_done
);

   function automatic line_state_type take_byte(line_state_type st, logic [7:0] b);
      line_state_type r;
      logic [3:0]     d;
      logic           is_hex;
      r      = st;
      d      = '0;
      is_hex = 1'b0;
      if (b >= CH_DIG0 && b <= CH_DIG9) begin
         is_hex = 1'b1;
         d      = 4'(b - CH_DIG0);
      end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
         is_hex = 1'b1;
         d      = 4'(b - CH_UPPER_A + HEX_TEN);
      end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
         is_hex = 1'b1;
         d      = 4'(b - CH_LOWER_A + HEX_TEN);
      end
      if (!st.digits_closed) begin
         if (is_hex) begin
            // saturate once the top nibble is occupied
            if (st.acc[SIZE_W-1 -: 4] != '0) begin
               r.acc = '1;
            end else begin
               r.acc = {st.acc[SIZE_W-5:0], d};
            end
            r.digit_seen = 1'b1;
         end else if (!((b == CH_SP || b == CH_TAB) && !st.digit_seen)) begin
            r.digits_closed = 1'b1;
         end
      end
      return r;
   endfunction

   line_state_type after_cr;

   always_comb begin
      size_line_done = cur.cr_pending && (c == CH_LF);
      // a held CR not followed by LF is an ordinary line byte
      after_cr = cur.cr_pending ? take_byte(cur, CH_CR) : cur;
      if (c == CH_CR) begin
         nxt            = after_cr;
         nxt.cr_pending = 1'b1;
      end else begin
         nxt            = take_byte(after_cr, c);
         nxt.cr_pending = 1'b0;
      end
   end

endmodule

// ===== src/hcbd_core.sv =====
// Decoder core: input register, phase/count/line state and the per-byte update.
// Depends on hcbd_pkg and hcbd_line.
module hcbd_core
   import hcbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_ready,
   input  logic         out_busy,
   output logic         res_valid,
   output rsp_item_type res_item
);

   logic              in_valid_ff, in_valid_in;
   req_item_type      in_item_ff;
   phase_type         phase_ff, phase_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   line_state_type    line_ff, line_in;

   phase_type         base_phase;
   logic [SIZE_W-1:0] base_rem, rem_dec;
   line_state_type    base_line, line_nxt;
   logic              size_line_done, advance, res_hit;

   assign base_phase = in_item_ff.restart ? PH_SIZE : phase_ff;
   assign base_rem   = in_item_ff.restart ? '0 : rem_ff;
   assign base_line  = in_item_ff.restart ? LINE_CLEAR : line_ff;
   assign rem_dec    = base_rem - SIZE_W'(1);

   hcbd_line u_line (
      .cur            (base_line),
      .c              (in_item_ff.body_byte),
      .nxt            (line_nxt),
      .size_line_done (size_line_done)
   );

   always_comb begin
      phase_in               = base_phase;
      rem_in                 = base_rem;
      line_in                = base_line;
      res_hit                = 1'b0;
      res_item.payload_byte  = '0;
      res_item.event_res     = EV_PAYLOAD;
      unique case (base_phase)
         PH_SIZE: begin
            if (size_line_done) begin
               line_in = LINE_CLEAR;
               if (!base_line.digit_seen) begin
                  phase_in           = PH_FAIL;
                  res_hit            = 1'b1;
                  res_item.event_res = EV_MALFORMED;
               end else if (base_line.acc == '0) begin
                  phase_in           = PH_DONE;
                  res_hit            = 1'b1;
                  res_item.event_res = EV_LAST;
               end else begin
                  phase_in = PH_DATA;
                  rem_in   = base_line.acc;
               end
            end else begin
               line_in = line_nxt;
            end
         end
         PH_DATA: begin
            res_hit               = 1'b1;
            res_item.payload_byte = in_item_ff.body_byte;
            if (rem_dec == '0) begin
               phase_in = PH_TRAIL;
               rem_in   = TRAIL_LEN;
            end else begin
               rem_in = rem_dec;
            end
         end
         PH_TRAIL: begin
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_SIZE;
               line_in  = LINE_CLEAR;
            end
         end
         default: begin
            // finished or failed: bytes dropped until restart
         end
      endcase
   end

   // an empty input register holds a stale byte and issues nothing
   assign res_valid = in_valid_ff && res_hit;

   // bytes without a result never wait on the output side
   assign advance   = in_valid_ff && (!res_valid || !out_busy);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_SIZE;
         rem_ff      <= '0;
         line_ff     <= LINE_CLEAR;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
            line_ff  <= line_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

endmodule

// ===== src/hcbd_out.sv =====
// Result register: holds one result until the receiver takes it.
// Depends on hcbd_pkg.
module hcbd_out
   import hcbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         take,
   output logic         out_valid,
   output logic         out_busy,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_busy  = valid_ff && !take;
   assign out_item  = item_ff;

endmodule

// ===== src/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
// Depends on hcbd_pkg, hcbd_if, hcbd_core and hcbd_out.
//
// Usage
//  - req_ch carries the raw body, one byte per transfer (body_byte), with restart
//    set on the first byte of a new body to clear all decoder state first.
//  - rsp_ch carries at most one result per request transfer: a payload byte
//    (event_res = payload), the last-chunk mark, or a malformed size line mark.
//    Size-line bytes other than the closing LF and the two bytes after each chunk produce nothing.
//  - Throughput: one byte per cycle unless stalled. The per-byte state update is a
//    single 64-bit decrement/compare or shift plus small selection.
//  - Path: a byte accepted into the input register is decoded from there; its
//    result is then loaded into the result register, which drives rsp_ch.valid,
//    once that register is free or being emptied.
//  - Stall: while a result waits in the result register, the next byte can
//    still be taken; a byte that itself produces a result then waits in the
//    input register, and req_ch.ready drops until the receiver takes the
//    waiting result. Bytes that produce no result pass straight through.
//  - Reset (synchronous, active high) empties both registers and returns the
//    decoder to reading a size line with an empty accumulator.
module http_chunked_body_decoder
   import hcbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req_ch,
   hcbd_rsp_if.source rsp_ch
);

   req_item_type req_item;
   rsp_item_type res_item, out_item;
   logic         res_valid, out_busy, out_valid, req_ready;

   assign req_item.body_byte = req_ch.body_byte;
   assign req_item.restart   = req_ch.restart;
   assign req_ch.ready       = req_ready;

   hcbd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .out_busy  (out_busy),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // a result is loaded only when the register is free or being emptied
   hcbd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid && !out_busy),
      .load_item (res_item),
      .take      (rsp_ch.ready),
      .out_valid (out_valid),
      .out_busy  (out_busy),
      .out_item  (out_item)
   );

   assign rsp_ch.valid        = out_valid;
   assign rsp_ch.payload_byte = out_item.payload_byte;
   assign rsp_ch.event_res    = out_item.event_res;

endmodule
